### src/ssd_pkg.sv
// Shared types, command codes and digit glyphs for the LED display frame encoder.
// No dependencies; every other file except ssd_ifs imports this package.
`default_nettype none

package ssd_pkg;

  typedef enum logic [2:0] {
    OP_DECIMAL = 3'd0,
    OP_TENTHS  = 3'd1,
    OP_TIME    = 3'd2,
    OP_RAW     = 3'd3,
    OP_BRIGHT  = 3'd4
  } op_t;

  // Driver command bytes
  localparam logic [7:0] CMD_DATA_WRITE  = 8'h40;
  localparam logic [7:0] CMD_ADDR_SET    = 8'hC0;
  localparam logic [7:0] CMD_DISPLAY_OFF = 8'h80;
  localparam logic [7:0] CMD_DISPLAY_ON  = 8'h88;
  localparam logic [7:0] POINT_BIT       = 8'h80;

  localparam logic [13:0] MAX_DECIMAL      = 14'd9999;
  localparam logic [15:0] MAX_DECIMAL_IN   = 16'd9999;
  localparam logic [6:0]  MAX_TWO_DIGIT    = 7'd99;
  localparam logic [2:0]  MAX_LEVEL_CODE   = 3'd7;

  // x / 100 for x <= 9999 and x / 10 for x <= 99 by reciprocal multiply
  localparam logic [12:0] RECIP_HUNDRED       = 13'd5243;
  localparam int          RECIP_HUNDRED_SHIFT = 19;
  localparam logic [7:0]  RECIP_TEN           = 8'd205;
  localparam int          RECIP_TEN_SHIFT     = 11;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Position within a segment write
  localparam logic [2:0] STEP_MODE_CMD = 3'd0;
  localparam logic [2:0] STEP_ADDR_CMD = 3'd1;
  localparam logic [2:0] STEP_DIGIT0   = 3'd2;
  localparam logic [2:0] STEP_LAST     = 3'd5;

  typedef struct packed {
    logic            bright;  // single control byte in seg[0]
    logic [3:0][7:0] seg;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_push_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_head_t;

  typedef struct packed {
    op_t             op;
    logic            sep;
    logic [13:0]     num;
    logic [6:0]      hi;
    logic [6:0]      lo;
    logic [6:0]      quo;
    logic [3:0][7:0] raw;
    logic [7:0]      cmd;
  } front_item_t;

  function automatic logic [7:0] glyph(input logic [3:0] d);
    logic [7:0] g;
    case (d)
      4'd0:    g = 8'h3f;
      4'd1:    g = 8'h06;
      4'd2:    g = 8'h5b;
      4'd3:    g = 8'h4f;
      4'd4:    g = 8'h66;
      4'd5:    g = 8'h6d;
      4'd6:    g = 8'h7d;
      4'd7:    g = 8'h07;
      4'd8:    g = 8'h7f;
      4'd9:    g = 8'h6f;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

### src/ssd_ifs.sv
// Valid/ready channel interfaces: display requests in, bus bytes out.
// Standalone; payload fields follow the block's item definitions.
`default_nettype none

interface ssd_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic signed [15:0] value;
  logic signed [7:0]  hours;
  logic signed [7:0]  minutes;
  logic               show_separator;
  logic [7:0]         digit0_segments;
  logic [7:0]         digit1_segments;
  logic [7:0]         digit2_segments;
  logic [7:0]         digit3_segments;
  logic signed [7:0]  brightness;

  modport source (
    output valid, operation, value, hours, minutes, show_separator,
    output digit0_segments, digit1_segments, digit2_segments, digit3_segments,
    output brightness,
    input  ready
  );
  modport sink (
    input  valid, operation, value, hours, minutes, show_separator,
    input  digit0_segments, digit1_segments, digit2_segments, digit3_segments,
    input  brightness,
    output ready
  );
endinterface

interface ssd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] bus_byte;
  logic       start_before;
  logic       stop_after;
  logic       last;

  modport source (output valid, bus_byte, start_before, stop_after, last, input ready);
  modport sink   (input valid, bus_byte, start_before, stop_after, last, output ready);
endinterface

`default_nettype wire

### src/ssd_front.sv
// Front end: accepts requests, clamps and splits numbers into digits, builds queue entries.
// Depends on ssd_pkg and ssd_req_if.
`default_nettype none

module ssd_front (
  input  logic                clk,
  input  logic                rst,
  ssd_req_if.sink             req,
  input  logic                queue_full,
  output ssd_pkg::queue_push_t push
);
  import ssd_pkg::*;

  logic        adv;
  op_t         op_in;
  logic        s1_keep;
  logic        s1_valid, s2_valid, s3_valid;
  front_item_t s1, s2, s3;
  front_item_t s1_next, s2_next, s3_next;
  logic [26:0] quo_prod;
  logic [13:0] rem;
  logic [14:0] hi_prod, lo_prod;
  logic [3:0]  hi_tens, hi_ones, lo_tens, lo_ones;

  assign op_in     = op_t'(req.operation);
  assign adv       = !(s3_valid && queue_full);
  assign req.ready = adv;

  // Stage 1: clamp inputs, work out the brightness byte
  always_comb begin
    s1_next     = '0;
    s1_next.op  = op_in;
    s1_next.sep = req.show_separator;

    if (req.value[15])
      s1_next.num = '0;
    else if (req.value > $signed(MAX_DECIMAL_IN))
      s1_next.num = MAX_DECIMAL;
    else
      s1_next.num = req.value[13:0];

    if (req.hours[7])
      s1_next.hi = '0;
    else if (req.hours[6:0] > MAX_TWO_DIGIT)
      s1_next.hi = MAX_TWO_DIGIT;
    else
      s1_next.hi = req.hours[6:0];

    if (req.minutes[7])
      s1_next.lo = '0;
    else if (req.minutes[6:0] > MAX_TWO_DIGIT)
      s1_next.lo = MAX_TWO_DIGIT;
    else
      s1_next.lo = req.minutes[6:0];

    if (req.brightness[7] || req.brightness == 8'sd0)
      s1_next.cmd = CMD_DISPLAY_OFF;
    else if (req.brightness[6:3] != 4'd0)
      s1_next.cmd = CMD_DISPLAY_ON | {5'd0, MAX_LEVEL_CODE};
    else
      s1_next.cmd = CMD_DISPLAY_ON | {5'd0, 3'(req.brightness[2:0] - 3'd1)};

    s1_next.raw[0] = req.digit0_segments;
    s1_next.raw[1] = req.digit1_segments;
    s1_next.raw[2] = req.digit2_segments;
    s1_next.raw[3] = req.digit3_segments;

    case (op_in)
      OP_DECIMAL, OP_TENTHS, OP_TIME, OP_RAW, OP_BRIGHT: s1_keep = 1'b1;
      default:                                            s1_keep = 1'b0;
    endcase
  end

  // Stage 2: quotient by one hundred
  always_comb begin
    quo_prod    = 27'(s1.num) * 27'(RECIP_HUNDRED);
    s2_next     = s1;
    s2_next.quo = quo_prod[RECIP_HUNDRED_SHIFT +: 7];
  end

  // Stage 3: remainder, pick the two digit pairs
  always_comb begin
    rem     = s2.num - 14'(s2.quo) * 14'd100;
    s3_next = s2;
    case (s2.op)
      OP_DECIMAL, OP_TENTHS: begin
        s3_next.hi = s2.quo;
        s3_next.lo = rem[6:0];
      end
      default: ;
    endcase
  end

  // Split both pairs into tens and ones, format the four digits
  always_comb begin
    hi_prod = 15'(s3.hi) * 15'(RECIP_TEN);
    lo_prod = 15'(s3.lo) * 15'(RECIP_TEN);
    hi_tens = hi_prod[RECIP_TEN_SHIFT +: 4];
    lo_tens = lo_prod[RECIP_TEN_SHIFT +: 4];
    hi_ones = 4'(s3.hi - 7'(hi_tens) * 7'd10);
    lo_ones = 4'(s3.lo - 7'(lo_tens) * 7'd10);

    push.valid        = s3_valid && adv;
    push.entry.bright = 1'b0;
    push.entry.seg    = '0;
    case (s3.op)
      OP_DECIMAL, OP_TIME: begin
        push.entry.seg[0] = glyph(hi_tens);
        push.entry.seg[1] = glyph(hi_ones) | {s3.sep, 7'd0};
        push.entry.seg[2] = glyph(lo_tens);
        push.entry.seg[3] = glyph(lo_ones);
      end
      OP_TENTHS: begin
        // blank leading zeros of the whole part above the units digit
        push.entry.seg[0] = (hi_tens != 4'd0) ? glyph(hi_tens) : 8'h00;
        push.entry.seg[1] = (s3.hi != 7'd0) ? glyph(hi_ones) : 8'h00;
        push.entry.seg[2] = glyph(lo_tens) | POINT_BIT;
        push.entry.seg[3] = glyph(lo_ones);
      end
      OP_RAW: begin
        push.entry.seg = s3.raw;
      end
      OP_BRIGHT: begin
        push.entry.bright = 1'b1;
        push.entry.seg[0] = s3.cmd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= req.valid && s1_keep;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
    end
  end

endmodule

`default_nettype wire

### src/ssd_queue.sv
// Short queue of formatted entries between front and back end.
// Depends on ssd_pkg.
`default_nettype none

module ssd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  ssd_pkg::queue_push_t push,
  input  logic                 pop,
  output logic                 full,
  output ssd_pkg::queue_head_t head
);
  import ssd_pkg::*;

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid)
        wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)
        rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push.valid && !pop)
        count <= count + QCNT_W'(1);
      else if (!push.valid && pop)
        count <= count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid)
      slots[wr_ptr] <= push.entry;
  end

endmodule

`default_nettype wire

### src/ssd_back.sv
// Back end: walks each queue entry and drives one framed bus byte per cycle while result.ready is high.
// Depends on ssd_pkg and ssd_byte_if.
`default_nettype none

module ssd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  ssd_pkg::queue_head_t head,
  output logic                 pop,
  ssd_byte_if.source           result
);
  import ssd_pkg::*;

  logic [2:0] step;
  logic [2:0] digit_idx;
  logic       out_valid;
  logic       load;
  logic       final_byte;
  logic [7:0] byte_next;
  logic       start_next, stop_next, last_next;

  assign load         = head.valid && (!out_valid || result.ready);
  assign final_byte   = head.entry.bright || (step == STEP_LAST);
  assign pop          = load && final_byte;
  assign digit_idx    = step - STEP_DIGIT0;
  assign result.valid = out_valid;

  always_comb begin
    start_next = 1'b0;
    stop_next  = 1'b0;
    last_next  = 1'b0;
    if (head.entry.bright) begin
      byte_next  = head.entry.seg[0];
      start_next = 1'b1;
      stop_next  = 1'b1;
      last_next  = 1'b1;
    end else begin
      case (step)
        STEP_MODE_CMD: begin
          byte_next  = CMD_DATA_WRITE;
          start_next = 1'b1;
          stop_next  = 1'b1;
        end
        STEP_ADDR_CMD: begin
          byte_next  = CMD_ADDR_SET;
          start_next = 1'b1;
        end
        default: begin
          byte_next = head.entry.seg[digit_idx[1:0]];
          stop_next = (step == STEP_LAST);
          last_next = (step == STEP_LAST);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= STEP_MODE_CMD;
    end else if (load) begin
      out_valid <= 1'b1;
      step      <= final_byte ? STEP_MODE_CMD : step + 3'd1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.bus_byte     <= byte_next;
      result.start_before <= start_next;
      result.stop_after   <= stop_next;
      result.last         <= last_next;
    end
  end

endmodule

`default_nettype wire

### src/seven_segment_display_frame_encoder.sv
// Top level of the LED display frame encoder: front end, entry queue, back end.
// Depends on ssd_pkg, ssd_ifs, ssd_front, ssd_queue and ssd_back.
//
//   port     dir  handshake     payload
//   req      in   valid/ready   operation, value, hours, minutes, show_separator,
//                               digit0..3_segments, brightness
//   result   out  valid/ready   bus_byte, start_before, stop_after, last
//
// An accepted request passes through front registers s1, s2 and s3 into the queue;
// the back end registers each byte it sends. The output register sends one byte
// per cycle while ready; a segment write is six bytes and a brightness request one.
// The queue holds four entries, so the front keeps accepting while the back drains.
// Unused operation codes are accepted and produce no bytes.
// rst is synchronous and clears all valid flags, queue pointers and the byte counter.
`default_nettype none

module seven_segment_display_frame_encoder (
  input  logic       clk,
  input  logic       rst,
  ssd_req_if.sink    req,
  ssd_byte_if.source result
);
  import ssd_pkg::*;

  queue_push_t push;
  queue_head_t head;
  logic        queue_full;
  logic        pop;

  ssd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .queue_full (queue_full),
    .push       (push)
  );

  ssd_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (queue_full),
    .head (head)
  );

  ssd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule

`default_nettype wire

### src/ssd_checker.sv
// Port-level checks on the encoder's output framing, bound to the top level.
// Depends on ssd_pkg and seven_segment_display_frame_encoder.
`default_nettype none

module ssd_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_ready,
  input logic [7:0] result_byte,
  input logic       result_start,
  input logic       result_stop,
  input logic       result_last
);
  import ssd_pkg::*;

  logic prev_open;

  // Remember whether the last transaction was the data-write command
  always_ff @(posedge clk) begin
    if (rst)
      prev_open <= 1'b0;
    else if (result_valid && result_ready)
      prev_open <= result_start && result_stop && !result_last;
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_last_has_stop: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_last |-> result_stop)
    else $error("final byte without stop");

  a_open_frame: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stop && !result_last |->
      result_start && result_byte == CMD_DATA_WRITE)
    else $error("stop inside a write on a byte other than the data command");

  a_addr_follows: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_start && !result_stop |->
      prev_open && result_byte == CMD_ADDR_SET)
    else $error("address command not right after the data command");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_byte))
    else $error("output dropped or changed while stalled");

endmodule

bind seven_segment_display_frame_encoder ssd_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_byte  (result.bus_byte),
  .result_start (result.start_before),
  .result_stop  (result.stop_after),
  .result_last  (result.last)
);

`default_nettype wire
